@@ src/fractal_perlin_height_defines.svh @@
// assertion macros shared by the noise block
`ifndef FRACTAL_PERLIN_HEIGHT_DEFINES_SVH
`define FRACTAL_PERLIN_HEIGHT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define FPH_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define FPH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/fph_pkg.sv @@
`timescale 1ns / 1ps
package fph_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 1024;

    localparam int unsigned OP_W     = 1;
    localparam int unsigned IDX_W    = 10;
    localparam int unsigned GRAD_W   = 16;
    localparam int unsigned POS_W    = 24;
    localparam int unsigned HEIGHT_W = 20;
    localparam int unsigned ENTRY_W  = 2 * GRAD_W;

    localparam int unsigned FRAC_W   = 17;
    localparam int unsigned CELL_W   = 9;
    localparam int unsigned RAW_W    = 15;
    localparam int unsigned EASE_W   = 18;
    localparam int unsigned DOT_W    = 36;
    localparam int unsigned N_OCT    = 3;
    localparam int unsigned N_CORNER = 4;

    localparam int unsigned HASH_X   = 41;
    localparam int unsigned HASH_Y   = 43;

    // reduction steps: depth >= 16 and raw hash < 2^15
    localparam int unsigned MOD_STEPS = 11;
    localparam int unsigned MOD_SPLIT = 5;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    typedef struct packed {
        logic signed [37:0] ph;
        logic [35:0]        pl;
    } lerp_prod_t;

endpackage

@@ src/fph_in_if.sv @@
`timescale 1ns / 1ps
interface fph_in_if;
    import fph_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            operation;
    logic [IDX_W-1:0]           entry_index;
    logic signed [GRAD_W-1:0]   gradient_x;
    logic signed [GRAD_W-1:0]   gradient_y;
    logic signed [POS_W-1:0]    pos_x;
    logic signed [POS_W-1:0]    pos_y;

    modport source (output valid, operation, entry_index, gradient_x, gradient_y,
                    pos_x, pos_y, input ready);
    modport sink (input valid, operation, entry_index, gradient_x, gradient_y,
                  pos_x, pos_y, output ready);
endinterface

@@ src/fph_out_if.sv @@
`timescale 1ns / 1ps
interface fph_out_if;
    import fph_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [HEIGHT_W-1:0] height;

    modport source (output valid, height, input ready);
    modport sink (input valid, height, output ready);
endinterface

@@ src/fph_ram.sv @@
`timescale 1ns / 1ps
module fph_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/fractal_perlin_height.sv @@
`timescale 1ns / 1ps
// an evaluate beat passes stages s1 to s8 and the output register; a load ends at the table write
// throughput: one beat per cycle unless the result stalls, loads and evaluates mixed freely
// twelve table copies (three octaves, four corners) each give one read per cycle unless stalled
// a stalled result freezes the whole pipeline; loads write at the read stage
// reset clears valid bits only; the gradient table is undefined until loaded
`include "fractal_perlin_height_defines.svh"
module fractal_perlin_height #(
    parameter int unsigned TABLE_DEPTH = fph_pkg::TABLE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    fph_in_if.sink    sample,
    fph_out_if.source result
);
    import fph_pkg::*;

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    function automatic lerp_prod_t lerp_mul(input logic [EASE_W-1:0] e,
                                            input logic signed [DOT_W-1:0] a,
                                            input logic signed [DOT_W-1:0] b);
        logic signed [DOT_W:0] diff;
        logic signed [18:0]    dh;
        lerp_prod_t            r;
        diff = (DOT_W+1)'(b) - (DOT_W+1)'(a);
        dh   = diff[DOT_W:18];
        r.ph = signed'({1'b0, e}) * dh;
        r.pl = e * diff[17:0];
        return r;
    endfunction

    function automatic logic signed [DOT_W-1:0] lerp_add(input logic signed [DOT_W-1:0] a,
                                                         input lerp_prod_t p);
        logic signed [55:0] s;
        s = (56'(p.ph) <<< 18) + 56'(signed'({1'b0, p.pl}));
        s = (s + 56'sd65536) >>> 17;
        return DOT_W'(56'(a) + s);
    endfunction

    logic advance;
    logic out_valid_reg;
    logic signed [HEIGHT_W-1:0] height_reg;

    // valid chain
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s5_valid_reg, s6_valid_reg, s7_valid_reg, s8_valid_reg;
    logic [OP_W-1:0] s1_op_reg, s2_op_reg;

    // load payload
    logic [IDX_W-1:0]  s1_idx_reg, s2_idx_reg;
    logic [ENTRY_W-1:0] s1_grad_reg, s2_grad_reg;

    // per-octave fractions and ease products
    logic [FRAC_W-1:0] fx_s1_reg [N_OCT], fy_s1_reg [N_OCT];
    logic [FRAC_W-1:0] fx_s2_reg [N_OCT], fy_s2_reg [N_OCT];
    logic [FRAC_W-1:0] fx_s3_reg [N_OCT], fy_s3_reg [N_OCT];
    logic [33:0] tx2_s2_reg [N_OCT], ty2_s2_reg [N_OCT];
    logic [33:0] tx2_s3_reg [N_OCT], ty2_s3_reg [N_OCT];
    logic [50:0] tx3_s3_reg [N_OCT], ty3_s3_reg [N_OCT];
    logic [EASE_W-1:0] ex_s4_reg [N_OCT], ey_s4_reg [N_OCT];
    logic [EASE_W-1:0] ey_s5_reg [N_OCT], ey_s6_reg [N_OCT];

    // hash indexes
    logic [RAW_W-1:0] raw_next [N_OCT][N_CORNER];
    logic [RAW_W-1:0] raw_s1_reg [N_OCT][N_CORNER];
    logic [RAW_W-1:0] mod_next [N_OCT][N_CORNER];
    logic [RAW_W-1:0] mod_s2_reg [N_OCT][N_CORNER];
    logic [AW-1:0]    raddr [N_OCT][N_CORNER];
    logic [ENTRY_W-1:0] rdata [N_OCT][N_CORNER];

    // noise values
    logic signed [DOT_W-1:0] dot_next [N_OCT][N_CORNER];
    logic signed [DOT_W-1:0] dot_s4_reg [N_OCT][N_CORNER];
    lerp_prod_t              px_next [N_OCT][2];
    lerp_prod_t              px_s5_reg [N_OCT][2];
    logic signed [DOT_W-1:0] ax_s5_reg [N_OCT][2];
    logic signed [DOT_W-1:0] m_next [N_OCT][2];
    logic signed [DOT_W-1:0] m_s6_reg [N_OCT][2];
    lerp_prod_t              py_next [N_OCT];
    lerp_prod_t              py_s7_reg [N_OCT];
    logic signed [DOT_W-1:0] ay_s7_reg [N_OCT];
    logic signed [DOT_W-1:0] n_next [N_OCT];
    logic signed [DOT_W-1:0] n_s8_reg [N_OCT];

    logic [33:0] tx2_next [N_OCT], ty2_next [N_OCT];
    logic [50:0] tx3_next [N_OCT], ty3_next [N_OCT];
    logic [EASE_W-1:0] ex_next [N_OCT], ey_next [N_OCT];
    logic [FRAC_W-1:0] fx_next [N_OCT], fy_next [N_OCT];

    logic ram_we;
    logic [AW-1:0] ram_waddr;
    logic signed [HEIGHT_W-1:0] height_next;

    assign advance        = !out_valid_reg || result.ready;
    assign sample.ready   = advance;
    assign result.valid   = out_valid_reg;
    assign result.height  = height_reg;

    // stage 0: absolute position, cells, fractions, raw corner hash
    always_comb
    begin
        logic [POS_W-1:0]  ax, ay;
        logic [POS_W+1:0]  ux, uy;
        logic [CELL_W-1:0] cx, cy;
        logic [RAW_W-1:0]  hx, hy;
        ax = sample.pos_x[POS_W-1] ? (~sample.pos_x + 1'b1) : sample.pos_x;
        ay = sample.pos_y[POS_W-1] ? (~sample.pos_y + 1'b1) : sample.pos_y;
        for (int o = 0; o < N_OCT; o++)
        begin
            ux = (POS_W+2)'(ax) << (N_OCT - 1 - o);
            uy = (POS_W+2)'(ay) << (N_OCT - 1 - o);
            fx_next[o] = ux[FRAC_W-1:0];
            fy_next[o] = uy[FRAC_W-1:0];
            for (int c = 0; c < N_CORNER; c++)
            begin
                cx = ux[POS_W+1:FRAC_W] + CELL_W'(c % 2);
                cy = uy[POS_W+1:FRAC_W] + CELL_W'(c / 2);
                hx = RAW_W'(cx);
                hy = RAW_W'(cy);
                raw_next[o][c] = hx * RAW_W'(HASH_X) + hy * RAW_W'(HASH_Y);
            end
        end
    end

    // stage 1: upper half of the modulo reduction, squares for the ease
    always_comb
    begin
        logic [31:0] v;
        for (int o = 0; o < N_OCT; o++)
        begin
            tx2_next[o] = fx_s1_reg[o] * fx_s1_reg[o];
            ty2_next[o] = fy_s1_reg[o] * fy_s1_reg[o];
            for (int c = 0; c < N_CORNER; c++)
            begin
                v = 32'(raw_s1_reg[o][c]);
                for (int k = MOD_STEPS - 1; k >= MOD_SPLIT; k--)
                begin
                    if (v >= (32'(TABLE_DEPTH) << k))
                    begin
                        v = v - (32'(TABLE_DEPTH) << k);
                    end
                end
                mod_next[o][c] = RAW_W'(v);
            end
        end
    end

    // stage 2: lower half of the reduction feeds the table reads, cubes
    always_comb
    begin
        logic [31:0] v;
        for (int o = 0; o < N_OCT; o++)
        begin
            tx3_next[o] = tx2_s2_reg[o] * fx_s2_reg[o];
            ty3_next[o] = ty2_s2_reg[o] * fy_s2_reg[o];
            for (int c = 0; c < N_CORNER; c++)
            begin
                v = 32'(mod_s2_reg[o][c]);
                for (int k = MOD_SPLIT - 1; k >= 0; k--)
                begin
                    if (v >= (32'(TABLE_DEPTH) << k))
                    begin
                        v = v - (32'(TABLE_DEPTH) << k);
                    end
                end
                raddr[o][c] = AW'(v);
            end
        end
    end

    // loads write at the same stage evaluates read, so order is kept
    assign ram_we = advance && s2_valid_reg && (s2_op_reg == OP_LOAD)
                    && (32'(s2_idx_reg) < 32'(TABLE_DEPTH));
    assign ram_waddr = AW'(s2_idx_reg);

    for (genvar go = 0; go < N_OCT; go++)
    begin : g_oct
        for (genvar gc = 0; gc < N_CORNER; gc++)
        begin : g_corner
            fph_ram #(
                .WIDTH (ENTRY_W),
                .DEPTH (TABLE_DEPTH)
            ) u_ram (
                .clk   (clk),
                .we    (ram_we),
                .waddr (ram_waddr),
                .wdata (s2_grad_reg),
                .re    (advance),
                .raddr (raddr[go][gc]),
                .rdata (rdata[go][gc])
            );
        end
    end

    // stage 3: ease values and corner dot products
    always_comb
    begin
        logic [53:0] evx, evy;
        logic signed [GRAD_W-1:0] gx, gy;
        logic signed [FRAC_W:0]   ox, oy;
        logic signed [33:0]       prx, pry;
        for (int o = 0; o < N_OCT; o++)
        begin
            evx = ((54'(tx2_s3_reg[o]) * 54'd3) << 17) - (54'(tx3_s3_reg[o]) << 1)
                  + (54'd1 << 33);
            evy = ((54'(ty2_s3_reg[o]) * 54'd3) << 17) - (54'(ty3_s3_reg[o]) << 1)
                  + (54'd1 << 33);
            ex_next[o] = evx[EASE_W+33:34];
            ey_next[o] = evy[EASE_W+33:34];
            for (int c = 0; c < N_CORNER; c++)
            begin
                gx = rdata[o][c][GRAD_W-1:0];
                gy = rdata[o][c][ENTRY_W-1:GRAD_W];
                // far corner offset is the fraction minus one
                ox = (c % 2 == 1) ? {1'b1, fx_s3_reg[o]} : {1'b0, fx_s3_reg[o]};
                oy = (c / 2 == 1) ? {1'b1, fy_s3_reg[o]} : {1'b0, fy_s3_reg[o]};
                prx = gx * ox;
                pry = gy * oy;
                dot_next[o][c] = DOT_W'(prx) + DOT_W'(pry);
            end
        end
    end

    // stages 4 to 8: x blends, y blend, weighted sum
    always_comb
    begin
        logic signed [DOT_W+3:0] sum;
        logic signed [DOT_W-12:0] hr;
        for (int o = 0; o < N_OCT; o++)
        begin
            for (int h = 0; h < 2; h++)
            begin
                px_next[o][h] = lerp_mul(ex_s4_reg[o], dot_s4_reg[o][2*h],
                                         dot_s4_reg[o][2*h+1]);
                m_next[o][h]  = lerp_add(ax_s5_reg[o][h], px_s5_reg[o][h]);
            end
            py_next[o] = lerp_mul(ey_s6_reg[o], m_s6_reg[o][0], m_s6_reg[o][1]);
            n_next[o]  = lerp_add(ay_s7_reg[o], py_s7_reg[o]);
        end
        // octave 0 is frequency 4 (weight 1), octave 2 is frequency 1 (weight 4)
        sum = (DOT_W+4)'(n_s8_reg[0]) + ((DOT_W+4)'(n_s8_reg[1]) <<< 1)
              + ((DOT_W+4)'(n_s8_reg[2]) <<< 2);
        sum = (sum + (DOT_W+4)'(32768)) >>> 16;
        hr  = (DOT_W-11)'(sum);
        if (hr > (DOT_W-11)'(524287))
        begin
            height_next = HEIGHT_W'(524287);
        end
        else if (hr < -(DOT_W-11)'(524288))
        begin
            height_next = -HEIGHT_W'(524288);
        end
        else
        begin
            height_next = HEIGHT_W'(hr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= sample.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg && (s2_op_reg == OP_EVAL);
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            s6_valid_reg  <= s5_valid_reg;
            s7_valid_reg  <= s6_valid_reg;
            s8_valid_reg  <= s7_valid_reg;
            out_valid_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_op_reg   <= sample.operation;
            s1_idx_reg  <= sample.entry_index;
            s1_grad_reg <= {sample.gradient_y, sample.gradient_x};
            s2_op_reg   <= s1_op_reg;
            s2_idx_reg  <= s1_idx_reg;
            s2_grad_reg <= s1_grad_reg;
            height_reg  <= height_next;
            for (int o = 0; o < N_OCT; o++)
            begin
                fx_s1_reg[o]  <= fx_next[o];
                fy_s1_reg[o]  <= fy_next[o];
                fx_s2_reg[o]  <= fx_s1_reg[o];
                fy_s2_reg[o]  <= fy_s1_reg[o];
                fx_s3_reg[o]  <= fx_s2_reg[o];
                fy_s3_reg[o]  <= fy_s2_reg[o];
                tx2_s2_reg[o] <= tx2_next[o];
                ty2_s2_reg[o] <= ty2_next[o];
                tx2_s3_reg[o] <= tx2_s2_reg[o];
                ty2_s3_reg[o] <= ty2_s2_reg[o];
                tx3_s3_reg[o] <= tx3_next[o];
                ty3_s3_reg[o] <= ty3_next[o];
                ex_s4_reg[o]  <= ex_next[o];
                ey_s4_reg[o]  <= ey_next[o];
                ey_s5_reg[o]  <= ey_s4_reg[o];
                ey_s6_reg[o]  <= ey_s5_reg[o];
                py_s7_reg[o]  <= py_next[o];
                ay_s7_reg[o]  <= m_s6_reg[o][0];
                n_s8_reg[o]   <= n_next[o];
                for (int c = 0; c < N_CORNER; c++)
                begin
                    raw_s1_reg[o][c] <= raw_next[o][c];
                    mod_s2_reg[o][c] <= mod_next[o][c];
                    dot_s4_reg[o][c] <= dot_next[o][c];
                end
                for (int h = 0; h < 2; h++)
                begin
                    px_s5_reg[o][h] <= px_next[o][h];
                    ax_s5_reg[o][h] <= dot_s4_reg[o][2*h];
                    m_s6_reg[o][h]  <= m_next[o][h];
                end
            end
        end
    end

    `FPH_ASSERT_NEXT(a_last_stage_to_out, advance && s8_valid_reg, result.valid,
                     "last stage beat did not reach the output register")
    `FPH_ASSERT_NEXT(a_stall_freezes, !advance,
                     $stable(s1_valid_reg) && $stable(s8_valid_reg),
                     "pipeline moved while the result was stalled")
    `FPH_ASSERT_IMPL(a_write_is_load, ram_we,
                     s2_valid_reg && (s2_op_reg == OP_LOAD),
                     "table write without a load beat")

endmodule

@@ test/fph_height_checker.sv @@
`timescale 1ns / 1ps
module fph_height_checker
    import fph_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    fph_in_if    smp,
    fph_out_if   res,
    output int   errors,
    output int   outstanding,
    output int   evals_seen,
    output int   saturated_seen
);

    localparam longint ONE_Q17 = longint'(1) << FRAC_W;

    logic [ENTRY_W-1:0]          grads [TABLE_DEPTH_DEF];
    logic signed [HEIGHT_W-1:0]  heights_due [$];

    function automatic longint corner_term(longint cx, longint cy, longint ox, longint oy);
        longint slot;
        logic [ENTRY_W-1:0] g;
        slot = (HASH_X * cx + HASH_Y * cy) % TABLE_DEPTH_DEF;
        g = grads[slot];
        return longint'(signed'(g[15:0])) * ox + longint'(signed'(g[31:16])) * oy;
    endfunction

    function automatic longint smooth_q17(longint t);
        longint t2;
        t2 = t * t;
        return (3 * t2 * ONE_Q17 - 2 * t2 * t + (longint'(1) << 33)) >>> 34;
    endfunction

    // rounds half toward plus infinity, arithmetic shift floors
    function automatic longint blend(longint a, longint b, longint e);
        return a + ((e * (b - a) + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W);
    endfunction

    function automatic longint octave_q31(longint u, longint v);
        longint cx, cy, fx, fy, ex, ey, lo, hi;
        cx = u >> FRAC_W;
        cy = v >> FRAC_W;
        fx = u & (ONE_Q17 - 1);
        fy = v & (ONE_Q17 - 1);
        ex = smooth_q17(fx);
        ey = smooth_q17(fy);
        lo = blend(corner_term(cx, cy, fx, fy),
                   corner_term(cx + 1, cy, fx - ONE_Q17, fy), ex);
        hi = blend(corner_term(cx, cy + 1, fx, fy - ONE_Q17),
                   corner_term(cx + 1, cy + 1, fx - ONE_Q17, fy - ONE_Q17), ex);
        return blend(lo, hi, ey);
    endfunction

    function automatic logic signed [HEIGHT_W-1:0] terrain_height(
        logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py, output bit clipped);
        longint ax, ay, total, h;
        ax = longint'(px);
        ay = longint'(py);
        if (ax < 0) ax = -ax;
        if (ay < 0) ay = -ay;
        total = octave_q31(ax << 2, ay << 2) + 2 * octave_q31(ax << 1, ay << 1)
              + 4 * octave_q31(ax, ay);
        h = (total + (longint'(1) << 15)) >>> 16;
        clipped = 1'b1;
        if (h > 524287) h = 524287;
        else if (h < -524288) h = -524288;
        else clipped = 1'b0;
        return h[HEIGHT_W-1:0];
    endfunction

    initial begin
        errors = 0;
        outstanding = 0;
        evals_seen = 0;
        saturated_seen = 0;
    end

    always @(posedge clk) begin
        logic signed [HEIGHT_W-1:0] want;
        bit clipped;
        if (rst_n) begin
            if (res.valid && res.ready) begin
                if (heights_due.size() == 0) begin
                    $error("height beat with nothing expected: got %0d", res.height);
                    errors++;
                end else begin
                    want = heights_due.pop_front();
                    if (res.height !== want) begin
                        $error("height mismatch: expected %0d, got %0d", want, res.height);
                        errors++;
                    end
                end
            end
            if (smp.valid && smp.ready) begin
                if (smp.operation == OP_LOAD)
                    grads[smp.entry_index] = {smp.gradient_y, smp.gradient_x};
                else begin
                    want = terrain_height(smp.pos_x, smp.pos_y, clipped);
                    heights_due = {heights_due, want};
                    evals_seen++;
                    if (clipped) saturated_seen++;
                end
            end
            outstanding = heights_due.size();
        end
    end

endmodule

@@ test/tb_fractal_perlin_height.sv @@
`timescale 1ns / 1ps
module tb_fractal_perlin_height;
    import fph_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic clk = 1'b0;
    logic rst_n;
    int   errors, outstanding, evals_seen, saturated_seen;
    int   loads_sent;
    int   cycles;
    bit   calm_src, calm_snk, long_hold;

    fph_in_if  in_ch ();
    fph_out_if out_ch ();

    fractal_perlin_height dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (in_ch),
        .result (out_ch)
    );

    fph_height_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .smp            (in_ch),
        .res            (out_ch),
        .errors         (errors),
        .outstanding    (outstanding),
        .evals_seen     (evals_seen),
        .saturated_seen (saturated_seen)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // valid stays high across back-to-back beats
    task automatic push_beat(op_t op, logic [IDX_W-1:0] idx, logic [GRAD_W-1:0] gx,
                             logic [GRAD_W-1:0] gy, logic [POS_W-1:0] px,
                             logic [POS_W-1:0] py);
        int gap;
        bit hs;
        gap = calm_src ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= op;
        in_ch.entry_index <= idx;
        in_ch.gradient_x  <= gx;
        in_ch.gradient_y  <= gy;
        in_ch.pos_x       <= px;
        in_ch.pos_y       <= py;
        do
        begin
            @(negedge clk);
            hs = in_ch.ready;
            @(posedge clk);
        end while (!hs);
        if (op == OP_LOAD) loads_sent++;
    endtask

    function automatic logic [GRAD_W-1:0] pick_grad();
        unique case ($urandom_range(0, 7))
            0: return 16'sd16384;
            1: return -16'sd16384;
            2: return 16'h7FFF;
            3: return 16'h8000;
            4: return GRAD_W'($urandom);
            default: return GRAD_W'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_pos();
        unique case ($urandom_range(0, 5))
            0: return POS_W'($urandom_range(0, 1 << 18));
            1: return POS_W'(-$urandom_range(0, 1 << 18));
            2: return 24'h800000;
            default: return POS_W'($urandom);
        endcase
    endfunction

    task automatic load_entry(int idx);
        push_beat(OP_LOAD, IDX_W'(idx), pick_grad(), pick_grad(), POS_W'($urandom),
                  POS_W'($urandom));
    endtask

    task automatic eval_at(logic [POS_W-1:0] px, logic [POS_W-1:0] py);
        push_beat(OP_EVAL, IDX_W'($urandom), GRAD_W'($urandom), GRAD_W'($urandom), px, py);
    endtask

    // sender idles until every expected height has come back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        @(posedge clk);
    endtask

    initial
    begin
        in_ch.valid       <= 1'b0;
        in_ch.operation   <= OP_LOAD;
        in_ch.entry_index <= '0;
        in_ch.gradient_x  <= '0;
        in_ch.gradient_y  <= '0;
        in_ch.pos_x       <= '0;
        in_ch.pos_y       <= '0;
        rst_n = 1'b0;
        loads_sent = 0;
        calm_src = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole table so that no evaluate reads an unwritten entry
        for (int i = 0; i < TABLE_DEPTH_DEF; i++)
            load_entry(i);

        // directed corners
        push_beat(OP_LOAD, 10'd0, 16'sd16384, -16'sd16384, '0, '0);
        push_beat(OP_LOAD, 10'd1023, 16'h7FFF, 16'h8000, '0, '0);
        eval_at(24'd0, 24'd0);
        eval_at(24'h7FFFFF, 24'h7FFFFF);
        eval_at(24'h800000, 24'h800000);
        eval_at(24'h800000, 24'd0);
        eval_at(24'hFFFFFF, 24'h000001);
        eval_at(24'h00FFFF, 24'h01FFFF);
        eval_at(-24'sd65536, 24'd32768);
        eval_at(24'h7FFFFF, 24'h800000);
        push_beat(OP_LOAD, 10'd41, 16'h8000, 16'h8000, '0, '0);
        push_beat(OP_LOAD, 10'd43, 16'h7FFF, 16'h7FFF, '0, '0);
        eval_at(24'd0, 24'd0);
        eval_at(24'h008000, 24'h004000);
        eval_at(24'h010000, 24'h010000);
        eval_at(24'h555555, 24'hAAAAAA);

        for (int n = 0; n < 780; n++)
        begin
            if (n == 150) long_hold = 1'b1;
            if (n == 400) wait_drained();
            calm_src = (n >= 550 && n < 650);
            calm_snk = calm_src;
            if ($urandom_range(0, 9) < 3)
                load_entry($urandom_range(0, TABLE_DEPTH_DEF - 1));
            else
                eval_at(pick_pos(), pick_pos());
        end
        in_ch.valid <= 1'b0;

        wait_drained();
        repeat (30) @(posedge clk);
        $display("covered %0d gradient loads and %0d height evaluations", loads_sent, evals_seen);
        $display("%0d heights hit the saturation limits", saturated_seen);
        if (errors == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        bit hs;
        int stall;
        out_ch.ready <= 1'b0;
        calm_snk = 1'b0;
        long_hold = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                long_hold = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else
            begin
                stall = calm_snk ? 0 : $urandom_range(0, 5);
                if (stall > 0)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ch.ready <= 1'b1;
            do
            begin
                @(negedge clk);
                hs = out_ch.valid;
                @(posedge clk);
            end while (!hs);
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule
